// ----- rtl/calendar_clock_tick_top_defines.svh -----
// assertion macros for the calendar clock tick checker
// expects signals named clock and reset in the scope of use
`ifndef CALENDAR_CLOCK_TICK_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_TICK_TOP_DEFINES_SVH

// concurrent assertion on the rising clock, off while reset is high
`define CCT_ASSERT_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same, with a fixed message
`define CCT_ASSERT(lbl, prop) \
   `CCT_ASSERT_MSG(lbl, prop, "calendar clock tick check failed")

`endif

// ----- rtl/cct_pkg.sv -----
// package for the calendar clock tick block
// reset date and time, rollover limits and leap year constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

   localparam logic [5:0]  RESET_SECOND = 6'd5;
   localparam logic [5:0]  RESET_MINUTE = 6'd6;
   localparam logic [4:0]  RESET_HOUR   = 5'd16;
   localparam logic [4:0]  RESET_DAY    = 5'd23;
   localparam logic [3:0]  RESET_MONTH  = 4'd9;
   localparam logic [15:0] RESET_YEAR   = 16'd2012;

   localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
   localparam logic [6:0]  MINS_PER_HOUR = 7'd60;
   localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
   localparam logic [5:0]  DAY_OVERFLOW  = 6'd32;
   localparam logic [4:0]  MONTH_LIMIT   = 5'd13;

   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_NOV = 4'd11;

   // multiplicative inverse of 25 modulo 2^16, and the largest quotient
   localparam logic [15:0] INV_25     = 16'd23593;
   localparam logic [15:0] DIV_25_MAX = 16'd2621;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/cct_if.sv -----
// valid/ready channel interfaces for the calendar clock tick block
// request carries a tick or load item, response the date and time; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface cct_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [5:0]  load_second;
   logic [5:0]  load_minute;
   logic [4:0]  load_hour;
   logic [4:0]  load_day;
   logic [3:0]  load_month;
   logic [15:0] load_year;

   modport source (
      output valid, func, load_second, load_minute, load_hour, load_day, load_month,
             load_year,
      input  ready
   );
   modport sink (
      input  valid, func, load_second, load_minute, load_hour, load_day, load_month,
             load_year,
      output ready
   );
endinterface

interface cct_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second_now;
   logic [5:0]  minute_now;
   logic [4:0]  hour_now;
   logic [4:0]  day_now;
   logic [3:0]  month_now;
   logic [15:0] year_now;

   modport source (
      output valid, second_now, minute_now, hour_now, day_now, month_now, year_now,
      input  ready
   );
   modport sink (
      input  valid, second_now, minute_now, hour_now, day_now, month_now, year_now,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/calendar_clock_tick_top.sv -----
// calendar clock tick top level: real-time clock with gregorian calendar
// depends on cct_pkg and the channel interfaces in cct_if
//
// usage
//   req_ch carries one item per handshake: func low advances the clock one
//   second, func high loads the full date and time from the load fields.
//   rsp_ch returns exactly one item per request: the date and time after it.
// datapath
//   an accepted item sits in the input register, its result is registered
//   into the output register and can be taken on rsp_ch when the output
//   is free.
// throughput
//   one item per cycle while rsp_ch is not held off; the whole cascade from
//   seconds to year, with the leap year test (one 16 bit multiply by a
//   constant), settles between the input register and the output register.
// reset
//   synchronous, active high; the clock restarts at 2012-09-23 16:06:05 and
//   both channel stages empty.
// stalls
//   while rsp_ch is held off the result stays put and one more request can
//   still be taken into the input register; then req_ch ready drops.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_tick_top (
   input  wire logic clock,
   input  wire logic reset,
   cct_req_if.sink   req_ch,
   cct_rsp_if.source rsp_ch
);

   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic [5:0]  in_second_ff;
   logic [5:0]  in_minute_ff;
   logic [4:0]  in_hour_ff;
   logic [4:0]  in_day_ff;
   logic [3:0]  in_month_ff;
   logic [15:0] in_year_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [15:0] year_ff, year_in;

   logic        req_take;
   logic        advance;

   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [5:0]  day_inc;
   logic [4:0]  month_inc;
   logic [4:0]  month_mid;
   logic        sec_carry, min_carry, hour_carry;
   logic        month_end;

   logic [15:0] year_mul;
   logic        div_4, div_16, div_25, div_100, div_400;
   logic        common_year;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // leap year test
   assign year_mul    = 16'(32'(year_ff) * 32'(cct_pkg::INV_25));
   assign div_4       = (year_ff[1:0] == 2'd0);
   assign div_16      = (year_ff[3:0] == 4'd0);
   assign div_25      = (year_mul <= cct_pkg::DIV_25_MAX);
   assign div_100     = div_4 && div_25;
   assign div_400     = div_16 && div_25;
   assign common_year = div_100 ? !div_400 : !div_4;

   // cascade
   assign sec_inc    = {1'b0, sec_ff} + 7'd1;
   assign min_inc    = {1'b0, min_ff} + 7'd1;
   assign hour_inc   = {1'b0, hour_ff} + 6'd1;
   assign day_inc    = {1'b0, day_ff} + 6'd1;
   assign month_inc  = {1'b0, month_ff} + 5'd1;
   assign sec_carry  = (sec_inc >= cct_pkg::SECS_PER_MIN);
   assign min_carry  = sec_carry && (min_inc >= cct_pkg::MINS_PER_HOUR);
   assign hour_carry = min_carry && (hour_inc >= cct_pkg::HOURS_PER_DAY);

   always_comb begin
      case (day_inc)
         6'd29:   month_end = (month_ff == cct_pkg::MONTH_FEB) && common_year;
         6'd30:   month_end = (month_ff == cct_pkg::MONTH_FEB);
         6'd31:   month_end = (month_ff == cct_pkg::MONTH_APR) ||
                              (month_ff == cct_pkg::MONTH_JUN) ||
                              (month_ff == cct_pkg::MONTH_SEP) ||
                              (month_ff == cct_pkg::MONTH_NOV);
         default: month_end = (day_inc >= cct_pkg::DAY_OVERFLOW);
      endcase
   end

   assign month_mid = month_end ? month_inc : {1'b0, month_ff};

   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      if (in_func_ff == cct_pkg::FUNC_LOAD) begin
         sec_in   = in_second_ff;
         min_in   = in_minute_ff;
         hour_in  = in_hour_ff;
         day_in   = in_day_ff;
         month_in = in_month_ff;
         year_in  = in_year_ff;
      end else begin
         sec_in = sec_carry ? 6'(sec_inc - cct_pkg::SECS_PER_MIN) : sec_inc[5:0];
         if (sec_carry) begin
            min_in = min_carry ? 6'd0 : min_inc[5:0];
         end
         if (min_carry) begin
            hour_in = hour_carry ? 5'd0 : hour_inc[4:0];
         end
         if (hour_carry) begin
            day_in = month_end ? 5'd1 : day_inc[4:0];
            if (month_mid >= cct_pkg::MONTH_LIMIT) begin
               month_in = 4'd1;
               year_in  = year_ff + 16'd1;
            end else begin
               month_in = month_mid[3:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff   <= req_ch.func;
         in_second_ff <= req_ch.load_second;
         in_minute_ff <= req_ch.load_minute;
         in_hour_ff   <= req_ch.load_hour;
         in_day_ff    <= req_ch.load_day;
         in_month_ff  <= req_ch.load_month;
         in_year_ff   <= req_ch.load_year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sec_ff       <= cct_pkg::RESET_SECOND;
         min_ff       <= cct_pkg::RESET_MINUTE;
         hour_ff      <= cct_pkg::RESET_HOUR;
         day_ff       <= cct_pkg::RESET_DAY;
         month_ff     <= cct_pkg::RESET_MONTH;
         year_ff      <= cct_pkg::RESET_YEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && in_valid_ff) begin
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.second_now = sec_ff;
   assign rsp_ch.minute_now = min_ff;
   assign rsp_ch.hour_now   = hour_ff;
   assign rsp_ch.day_now    = day_ff;
   assign rsp_ch.month_now  = month_ff;
   assign rsp_ch.year_now   = year_ff;

endmodule

`default_nettype wire

// ----- rtl/cct_checker.sv -----
// port level checker for the calendar clock tick top level, with its bind
// depends on calendar_clock_tick_top_defines.svh for the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_clock_tick_top_defines.svh"

module cct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [41:0] rsp_data
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   // stalled result item holds
   `CCT_ASSERT_MSG(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp item changed while stalled")
   // empty output means room for a request
   `CCT_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready)
   // an accepted item reaches the output once it is free
   `CCT_ASSERT_MSG(a_item_delivered, req_take ##1 !rsp_valid |=> rsp_valid, "accepted item not delivered")
   // both stages full and stalled, then ready follows the output side
   `CCT_ASSERT(a_full_stays, rsp_valid && !rsp_ready && !req_ready |=> req_ready == rsp_ready)

endmodule

bind calendar_clock_tick_top cct_checker u_cct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  ({rsp_ch.second_now, rsp_ch.minute_now, rsp_ch.hour_now,
                rsp_ch.day_now, rsp_ch.month_now, rsp_ch.year_now})
);

`default_nettype wire

// ----- test/tb.sv -----
// testbench for calendar_clock_tick_top: directed table of ticks and loads, then random items
// depends on cct_pkg, the channel interfaces in cct_if and the calendar_clock_tick_top rtl
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } clock_time_type;

   typedef struct packed {
      logic           func;
      clock_time_type value;
   } request_type;

   typedef struct packed {
      request_type    item;
      logic           typed;
      clock_time_type want;
   } table_row_type;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ITEMS_PER_RUN = 475;
   localparam int PRESSURE_AT   = 300;
   localparam int HOLD_CYCLES   = 80;

   logic clock;
   logic reset;

   cct_req_if req_ch ();
   cct_rsp_if rsp_ch ();

   calendar_clock_tick_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clock_time_type held_time;
   clock_time_type expected_times[$];
   table_row_type  directed_rows[$];
   int             mismatches   = 0;
   int             results_seen = 0;
   int             send_idle    = 0;
   int             stall_pct    = 0;
   int             cycle_count  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // one second on, with the cascade and its out of range behaviour
   function automatic clock_time_type advance_second(clock_time_type t);
      logic [6:0] sec_sum;
      logic [6:0] min_sum;
      logic [5:0] hour_sum;
      logic [5:0] day_sum;
      logic [4:0] month_next;
      logic       common_year;
      logic       month_over;
      sec_sum = {1'b0, t.second} + 7'd1;
      if (sec_sum < cct_pkg::SECS_PER_MIN) begin
         t.second = sec_sum[5:0];
         return t;
      end
      sec_sum  = sec_sum - cct_pkg::SECS_PER_MIN;
      t.second = sec_sum[5:0];
      min_sum  = {1'b0, t.minute} + 7'd1;
      if (min_sum < cct_pkg::MINS_PER_HOUR) begin
         t.minute = min_sum[5:0];
         return t;
      end
      t.minute = '0;
      hour_sum = {1'b0, t.hour} + 6'd1;
      if (hour_sum < cct_pkg::HOURS_PER_DAY) begin
         t.hour = hour_sum[4:0];
         return t;
      end
      t.hour      = '0;
      day_sum     = {1'b0, t.day} + 6'd1;
      common_year = (t.year % 100 == 0) ? (t.year % 400 != 0) : (t.year % 4 != 0);
      if (day_sum >= cct_pkg::DAY_OVERFLOW)
         month_over = 1'b1;
      else if (day_sum == 31)
         month_over = (t.month == cct_pkg::MONTH_APR) || (t.month == cct_pkg::MONTH_JUN) ||
                      (t.month == cct_pkg::MONTH_SEP) || (t.month == cct_pkg::MONTH_NOV);
      else if (day_sum == 30)
         month_over = (t.month == cct_pkg::MONTH_FEB);
      else if (day_sum == 29)
         month_over = (t.month == cct_pkg::MONTH_FEB) && common_year;
      else
         month_over = 1'b0;
      month_next = {1'b0, t.month};
      if (month_over) begin
         day_sum    = 6'd1;
         month_next = month_next + 5'd1;
      end
      t.day = day_sum[4:0];
      if (month_next >= cct_pkg::MONTH_LIMIT) begin
         month_next = 5'd1;
         t.year     = t.year + 16'd1;
      end
      t.month = month_next[3:0];
      return t;
   endfunction

   function automatic clock_time_type stamp(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s);
      clock_time_type t;
      t.year   = 16'(y);
      t.month  = 4'(mo);
      t.day    = 5'(d);
      t.hour   = 5'(h);
      t.minute = 6'(mi);
      t.second = 6'(s);
      return t;
   endfunction

   function automatic table_row_type load_row(clock_time_type t);
      return '{item: '{func: cct_pkg::FUNC_LOAD, value: t}, typed: 1'b1, want: t};
   endfunction

   function automatic table_row_type tick_row(logic typed, clock_time_type want);
      return '{item: '{func: cct_pkg::FUNC_TICK, value: '0}, typed: typed, want: want};
   endfunction

   // mostly ticks, loads close to a rollover, and some loads of raw bits
   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      int unsigned y;
      int unsigned length;
      logic        leap;
      pick           = $urandom_range(0, 99);
      r.func         = cct_pkg::FUNC_TICK;
      r.value.year   = 16'($urandom);
      r.value.month  = 4'($urandom);
      r.value.day    = 5'($urandom);
      r.value.hour   = 5'($urandom);
      r.value.minute = 6'($urandom);
      r.value.second = 6'($urandom);
      if (pick >= 70) begin
         r.func = cct_pkg::FUNC_LOAD;
         if (pick < 92) begin
            case ($urandom_range(0, 4))
               0: y = $urandom_range(0, 65535);
               1: y = $urandom_range(0, 163) * 400;
               2: y = $urandom_range(0, 655) * 100;
               3: y = $urandom_range(0, 16383) * 4;
               default: y = 65535 - $urandom_range(0, 1);
            endcase
            leap          = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            r.value.year  = 16'(y);
            r.value.month = 4'($urandom_range(1, 12));
            if (r.value.month == cct_pkg::MONTH_FEB)
               length = leap ? 29 : 28;
            else if (r.value.month == cct_pkg::MONTH_APR ||
                     r.value.month == cct_pkg::MONTH_JUN ||
                     r.value.month == cct_pkg::MONTH_SEP ||
                     r.value.month == cct_pkg::MONTH_NOV)
               length = 30;
            else
               length = 31;
            r.value.day    = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(1, length)
                                                            : length - $urandom_range(0, 1));
            r.value.hour   = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23);
            r.value.minute = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59);
            r.value.second = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 59)
                                                            : $urandom_range(55, 59));
         end
      end
      return r;
   endfunction

   task automatic send_item(request_type item, logic typed, clock_time_type want);
      while ($urandom_range(0, 99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= item.func;
      req_ch.load_second <= item.value.second;
      req_ch.load_minute <= item.value.minute;
      req_ch.load_hour   <= item.value.hour;
      req_ch.load_day    <= item.value.day;
      req_ch.load_month  <= item.value.month;
      req_ch.load_year   <= item.value.year;
      do
         @(posedge clock);
      while (!req_ch.ready);
      held_time = (item.func == cct_pkg::FUNC_LOAD) ? item.value : advance_second(held_time);
      expected_times.push_back(typed ? want : held_time);
   endtask

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   // result side: check, then decide ready for the next edge
   initial begin
      int             hold_left;
      bit             pressure_done;
      clock_time_type want;
      hold_left     = 0;
      pressure_done = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_times.size() == 0) begin
               mismatches++;
               $display("%0t: result with no item waiting, expected none actual %0d-%0d-%0d",
                        $time, rsp_ch.year_now, rsp_ch.month_now, rsp_ch.day_now);
            end else begin
               want = expected_times.pop_front();
               check_field("second", 32'(want.second), 32'(rsp_ch.second_now));
               check_field("minute", 32'(want.minute), 32'(rsp_ch.minute_now));
               check_field("hour",   32'(want.hour),   32'(rsp_ch.hour_now));
               check_field("day",    32'(want.day),    32'(rsp_ch.day_now));
               check_field("month",  32'(want.month),  32'(rsp_ch.month_now));
               check_field("year",   32'(want.year),   32'(rsp_ch.year_now));
            end
         end
         if (results_seen == PRESSURE_AT && !pressure_done) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      int send_idles[4];
      int stall_pcts[4];
      send_idles = '{0, 62, 0, 33};
      stall_pcts = '{0, 0, 62, 33};
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = cct_pkg::FUNC_TICK;
      req_ch.load_second = '0;
      req_ch.load_minute = '0;
      req_ch.load_hour   = '0;
      req_ch.load_day    = '0;
      req_ch.load_month  = '0;
      req_ch.load_year   = '0;
      held_time = '{year: cct_pkg::RESET_YEAR, month: cct_pkg::RESET_MONTH,
                    day: cct_pkg::RESET_DAY, hour: cct_pkg::RESET_HOUR,
                    minute: cct_pkg::RESET_MINUTE, second: cct_pkg::RESET_SECOND};

      // first tick after reset, full date wrap, leap rules, out of range loads
      directed_rows.push_back(tick_row(1'b1, stamp(2012, 9, 23, 16, 6, 6)));
      directed_rows.push_back(load_row(stamp(65535, 12, 31, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b1, stamp(0, 1, 1, 0, 0, 0)));
      directed_rows.push_back(load_row(stamp(0, 2, 28, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(1900, 2, 28, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2000, 2, 28, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2000, 2, 29, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2023, 2, 28, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2023, 4, 30, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2020, 7, 9, 3, 5, 63)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2021, 8, 31, 31, 63, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(2021, 0, 0, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(1999, 15, 31, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(65535, 13, 5, 23, 59, 59)));
      directed_rows.push_back(tick_row(1'b0, '0));
      directed_rows.push_back(load_row(stamp(0, 0, 0, 0, 0, 0)));
      directed_rows.push_back(tick_row(1'b0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int run = 0; run < 4; run++) begin
         send_idle = send_idles[run];
         stall_pct = stall_pcts[run];
         repeat (ITEMS_PER_RUN)
            send_item(random_request(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
      send_idle = 0;
      stall_pct = 0;

      while (expected_times.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cct_pkg.sv
rtl/cct_if.sv
rtl/calendar_clock_tick_top.sv
rtl/cct_checker.sv
test/tb.sv
